[hdl/sog_pkg.sv]
// Shared types, constants and width helpers for the sensor offset and gain scaler.
// Depends on nothing; every other file of the block imports it.
package sog_pkg;

  // Default width of a raw converter reading.
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int CH_W      = 2;
  localparam int OFS_W     = 12;
  localparam int SENS_W    = 13;
  localparam int OUT_W     = 23;
  localparam int REG_IDX_W = 3;
  localparam int NUM_CH    = 4;

  // Scale factor and its width, and the symmetric output bound.
  localparam int SCALE_FACTOR = 1000;
  localparam int SCALE_W      = 10;
  localparam int OUT_MAX      = 4095000;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;

  // Channel codes.
  typedef enum logic [CH_W-1:0] {
    CH_X    = 2'd0,
    CH_Y    = 2'd1,
    CH_Z    = 2'd2,
    CH_GYRO = 2'd3
  } sog_chan_e;

  // Register indexes of the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_OFS     = 3'd0,
    REG_Y_OFS     = 3'd1,
    REG_Z_OFS     = 3'd2,
    REG_GYRO_OFS  = 3'd3,
    REG_X_SENS    = 3'd4,
    REG_Y_SENS    = 3'd5,
    REG_Z_SENS    = 3'd6,
    REG_GYRO_SENS = 3'd7
  } sog_reg_e;

  // Reset values of the calibration registers, one per channel.
  localparam logic [OFS_W-1:0] OFS_RESET [NUM_CH] = '{
    12'd2048, 12'd2048, 12'd2048, 12'd1680
  };
  localparam logic [SENS_W-1:0] SENS_RESET [NUM_CH] = '{
    13'd819, 13'd819, 13'd819, 13'd825
  };

  // Sideband of one queued item: channel, result sign, zero-divisor flag.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            neg;
    logic            dz;
  } sog_tag_t;

  // Signed width of raw minus offset.
  function automatic int sog_diff_w(input int sample_bits);
    return ((sample_bits > OFS_W) ? sample_bits : OFS_W) + 1;
  endfunction

  // Unsigned width of |raw minus offset| times the scale factor.
  function automatic int sog_mag_w(input int sample_bits);
    return sog_diff_w(sample_bits) - 1 + SCALE_W;
  endfunction

endpackage

[hdl/sog_if.sv]
// Valid/ready channel interfaces for the scaler: raw readings in, scaled results out.
// Depends on sog_pkg for field widths.
interface sog_in_if #(
  parameter int SAMPLE_BITS = sog_pkg::SAMPLE_BITS_DEF
) ();
  import sog_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CH_W-1:0]        channel;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output channel, output raw_sample, input ready);
  modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

interface sog_out_if ();
  import sog_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] scaled_value;
  logic                    divide_by_zero;
  logic [CH_W-1:0]         result_channel;

  modport source (output valid, output scaled_value, output divide_by_zero,
                  output result_channel, input ready);
  modport sink   (input valid, input scaled_value, input divide_by_zero,
                  input result_channel, output ready);
endinterface

[hdl/sensor_offset_gain_scaler.sv]
// Top level of the sensor offset and gain scaler: front end, queue, divider back end.
// Depends on sog_pkg, sog_if, sog_front, sog_queue and sog_back.
//
//   Channel   Dir  Handshake      Payload
//   in_ch     in   valid/ready    channel, raw_sample
//   out_ch    out  valid/ready    scaled_value, divide_by_zero, result_channel
//   cfg_*     in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One reading is accepted per cycle when the output is taken every cycle.
// A reading passes the front stage, the queue, the divider, which resolves one
// quotient bit per pipeline stage, and then the output register.
// Reset is synchronous and active low; it empties all stages and the queue.
// An output stall freezes the divider; the queue and front stage keep
// accepting until the four-entry queue fills.
module sensor_offset_gain_scaler #(
  parameter int SAMPLE_BITS = sog_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sog_in_if.sink                        in_ch,
  sog_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sog_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [sog_pkg::SENS_W-1:0]    cfg_data
);
  import sog_pkg::*;

  localparam int MAG_W = sog_mag_w(SAMPLE_BITS);

  logic              push, pop, q_ready, q_valid;
  logic [MAG_W-1:0]  push_mag, head_mag;
  logic [SENS_W-1:0] push_den, head_den;
  sog_tag_t          push_tag, head_tag;

  sog_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .push      (push),
    .push_mag  (push_mag),
    .push_den  (push_den),
    .push_tag  (push_tag)
  );

  sog_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_mag (push_mag),
    .push_den (push_den),
    .push_tag (push_tag),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_mag (head_mag),
    .head_den (head_den),
    .head_tag (head_tag)
  );

  sog_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head_mag (head_mag),
    .head_den (head_den),
    .head_tag (head_tag),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[hdl/sog_front.sv]
// Front end: calibration registers, offset subtraction and scaling by 1000.
// Depends on sog_pkg and sog_in_if; feeds sog_queue.
module sog_front #(
  parameter int SAMPLE_BITS = sog_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sog_in_if.sink                            in_ch,
  input  logic                              cfg_we,
  input  logic [sog_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [sog_pkg::SENS_W-1:0]        cfg_data,
  input  logic                              q_ready,
  output logic                              push,
  output logic [sog_pkg::sog_mag_w(SAMPLE_BITS)-1:0] push_mag,
  output logic [sog_pkg::SENS_W-1:0]        push_den,
  output sog_pkg::sog_tag_t                 push_tag
);
  import sog_pkg::*;

  localparam int DIFF_W = sog_diff_w(SAMPLE_BITS);
  localparam int MAG_W  = sog_mag_w(SAMPLE_BITS);

  logic [OFS_W-1:0]  ofs_r  [NUM_CH];
  logic [SENS_W-1:0] sens_r [NUM_CH];

  logic                     fa_vld_r;
  logic [CH_W-1:0]          fa_ch_r;
  logic signed [DIFF_W-1:0] fa_diff_r;
  logic [SENS_W-1:0]        fa_sens_r;
  logic                     fa_vld_nxt;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic                     load;
  logic [DIFF_W-2:0]        abs_diff;

  // Calibration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ofs_r[c]  <= OFS_RESET[c];
        sens_r[c] <= SENS_RESET[c];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_OFS:     ofs_r[CH_X]     <= cfg_data[OFS_W-1:0];
        REG_Y_OFS:     ofs_r[CH_Y]     <= cfg_data[OFS_W-1:0];
        REG_Z_OFS:     ofs_r[CH_Z]     <= cfg_data[OFS_W-1:0];
        REG_GYRO_OFS:  ofs_r[CH_GYRO]  <= cfg_data[OFS_W-1:0];
        REG_X_SENS:    sens_r[CH_X]    <= cfg_data;
        REG_Y_SENS:    sens_r[CH_Y]    <= cfg_data;
        REG_Z_SENS:    sens_r[CH_Z]    <= cfg_data;
        REG_GYRO_SENS: sens_r[CH_GYRO] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a beat whenever the stage is empty or drains into the queue.
  assign push        = fa_vld_r && q_ready;
  assign in_ch.ready = !fa_vld_r || q_ready;
  assign load        = in_ch.valid && in_ch.ready;
  assign diff_nxt    = DIFF_W'(in_ch.raw_sample) - DIFF_W'(ofs_r[in_ch.channel]);

  always_comb begin
    fa_vld_nxt = fa_vld_r;
    if (load) begin
      fa_vld_nxt = 1'b1;
    end else if (push) begin
      fa_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
    end else begin
      fa_vld_r <= fa_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fa_ch_r   <= in_ch.channel;
      fa_diff_r <= diff_nxt;
      fa_sens_r <= sens_r[in_ch.channel];
    end
  end

  // Split into magnitude and sign so the divider works on unsigned values.
  assign abs_diff = fa_diff_r[DIFF_W-1] ? (DIFF_W-1)'(-fa_diff_r) : fa_diff_r[DIFF_W-2:0];
  assign push_mag = MAG_W'(abs_diff) * MAG_W'(SCALE_FACTOR);
  assign push_den = fa_sens_r[SENS_W-1] ? SENS_W'(-fa_sens_r) : fa_sens_r;

  always_comb begin
    push_tag.ch  = fa_ch_r;
    push_tag.neg = fa_diff_r[DIFF_W-1] ^ fa_sens_r[SENS_W-1];
    push_tag.dz  = (fa_sens_r == '0);
  end

endmodule

[hdl/sog_queue.sv]
// Short queue that decouples the front end from the divider pipeline.
// Depends on sog_pkg for the tag type and queue depth.
module sog_queue #(
  parameter int SAMPLE_BITS = sog_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       push,
  input  logic [sog_pkg::sog_mag_w(SAMPLE_BITS)-1:0] push_mag,
  input  logic [sog_pkg::SENS_W-1:0]                 push_den,
  input  sog_pkg::sog_tag_t                          push_tag,
  output logic                                       q_ready,
  input  logic                                       pop,
  output logic                                       q_valid,
  output logic [sog_pkg::sog_mag_w(SAMPLE_BITS)-1:0] head_mag,
  output logic [sog_pkg::SENS_W-1:0]                 head_den,
  output sog_pkg::sog_tag_t                          head_tag
);
  import sog_pkg::*;

  localparam int MAG_W = sog_mag_w(SAMPLE_BITS);
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [MAG_W-1:0]  mag_q [QDEPTH];
  logic [SENS_W-1:0] den_q [QDEPTH];
  sog_tag_t          tag_q [QDEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_ready  = (count_r != CNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign head_mag = mag_q[rd_ptr_r];
  assign head_den = den_q[rd_ptr_r];
  assign head_tag = tag_q[rd_ptr_r];

  // Occupancy follows push and pop; both may happen in one cycle.
  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mag_q[wr_ptr_r] <= push_mag;
      den_q[wr_ptr_r] <= push_den;
      tag_q[wr_ptr_r] <= push_tag;
    end
  end

endmodule

[hdl/sog_back.sv]
// Back end: pipelined restoring divider, one quotient bit per stage, then
// sign, saturation and the output register. Depends on sog_pkg and sog_out_if.
module sog_back #(
  parameter int SAMPLE_BITS = sog_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       q_valid,
  input  logic [sog_pkg::sog_mag_w(SAMPLE_BITS)-1:0] head_mag,
  input  logic [sog_pkg::SENS_W-1:0]                 head_den,
  input  sog_pkg::sog_tag_t                          head_tag,
  output logic                                       pop,
  sog_out_if.source                                  out_ch
);
  import sog_pkg::*;

  localparam int MAG_W = sog_mag_w(SAMPLE_BITS);
  localparam int REM_W = SENS_W - 1;
  localparam int CMP_W = (MAG_W > OUT_W) ? MAG_W : OUT_W;

  // Stage registers.
  logic              st_vld_r [MAG_W];
  logic [REM_W-1:0]  st_rem_r [MAG_W];
  logic [MAG_W-1:0]  st_num_r [MAG_W];
  logic [SENS_W-1:0] st_den_r [MAG_W];
  sog_tag_t          st_tag_r [MAG_W];

  // Stage inputs and the trial subtraction of each stage.
  logic              in_vld [MAG_W];
  logic [REM_W-1:0]  in_rem [MAG_W];
  logic [MAG_W-1:0]  in_num [MAG_W];
  logic [SENS_W-1:0] in_den [MAG_W];
  sog_tag_t          in_tag [MAG_W];
  logic [REM_W:0]    trial  [MAG_W];
  logic [REM_W:0]    sub    [MAG_W];
  logic              take   [MAG_W];

  logic                    back_en;
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] out_val_r, out_val_nxt;
  logic                    out_dz_r;
  logic [CH_W-1:0]         out_ch_r;
  logic [CMP_W-1:0]        q_ext;
  logic [OUT_W-2:0]        q_sat;

  // The whole pipeline moves when the output register is free or drained.
  assign back_en = !out_vld_r || out_ch.ready;
  assign pop     = back_en && q_valid;

  // Chain the stages: the queue head enters stage zero.
  always_comb begin
    in_vld[0] = q_valid;
    in_rem[0] = '0;
    in_num[0] = head_mag;
    in_den[0] = head_den;
    in_tag[0] = head_tag;
    for (int i = 1; i < MAG_W; i++) begin
      in_vld[i] = st_vld_r[i-1];
      in_rem[i] = st_rem_r[i-1];
      in_num[i] = st_num_r[i-1];
      in_den[i] = st_den_r[i-1];
      in_tag[i] = st_tag_r[i-1];
    end
    for (int i = 0; i < MAG_W; i++) begin
      trial[i] = {in_rem[i], in_num[i][MAG_W-1]};
      take[i]  = (trial[i] >= in_den[i]);
      sub[i]   = trial[i] - in_den[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAG_W; i++) begin
        st_vld_r[i] <= 1'b0;
      end
    end else if (back_en) begin
      for (int i = 0; i < MAG_W; i++) begin
        st_vld_r[i] <= in_vld[i];
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (back_en) begin
      for (int i = 0; i < MAG_W; i++) begin
        st_rem_r[i] <= take[i] ? sub[i][REM_W-1:0] : trial[i][REM_W-1:0];
        st_num_r[i] <= {in_num[i][MAG_W-2:0], take[i]};
        st_den_r[i] <= in_den[i];
        st_tag_r[i] <= in_tag[i];
      end
    end
  end

  // Saturate the magnitude, apply the sign, and force zero on a zero divisor.
  assign q_ext = CMP_W'(st_num_r[MAG_W-1]);
  assign q_sat = (q_ext > CMP_W'(OUT_MAX)) ? (OUT_W-1)'(OUT_MAX) : q_ext[OUT_W-2:0];

  always_comb begin
    if (st_tag_r[MAG_W-1].dz) begin
      out_val_nxt = '0;
    end else if (st_tag_r[MAG_W-1].neg) begin
      out_val_nxt = -$signed({1'b0, q_sat});
    end else begin
      out_val_nxt = $signed({1'b0, q_sat});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (back_en) begin
      out_vld_r <= st_vld_r[MAG_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_val_r <= out_val_nxt;
      out_dz_r  <= st_tag_r[MAG_W-1].dz;
      out_ch_r  <= st_tag_r[MAG_W-1].ch;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.scaled_value   = out_val_r;
  assign out_ch.divide_by_zero = out_dz_r;
  assign out_ch.result_channel = out_ch_r;

endmodule

[hdl/sog_checker.sv]
// Port-level checks of the scaler over time, and the bind that attaches them.
// Depends on sog_pkg and the sensor_offset_gain_scaler top level.
module sog_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [sog_pkg::OUT_W-1:0] out_scaled_value,
  input logic                             out_divide_by_zero
);
  import sog_pkg::*;

  localparam logic signed [OUT_W-1:0] LIM_HI = OUT_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] LIM_LO = -LIM_HI;

  // A stalled result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled_value))
    else $error("stalled result dropped or changed");

  // A zero divisor always yields a zero value.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_scaled_value == '0)
    else $error("divide-by-zero result is not zero");

  // Results stay inside the saturation bounds.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scaled_value <= LIM_HI) && (out_scaled_value >= LIM_LO))
    else $error("scaled value outside saturation bounds");

  // Reset empties the pipeline: nothing is offered in the next cycle.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind sensor_offset_gain_scaler sog_checker u_sog_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_scaled_value   (out_ch.scaled_value),
  .out_divide_by_zero (out_ch.divide_by_zero)
);

[tb/sv/sensor_offset_gain_scaler_tb.sv]
// Self-checking testbench for sensor_offset_gain_scaler: directed and random readings
// with a built-in calibration predictor. Depends on sog_pkg, sog_if and the block's RTL.
module sensor_offset_gain_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sog_pkg::*;

  localparam int RAW_W        = SAMPLE_BITS_DEF;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LAT     = 25;
  localparam int CHOKE_CYCLES = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int IDLE_PCT     = 32;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 112;

  // One raw reading and one calibrated result.
  typedef struct {
    sog_chan_e        ch;
    logic [RAW_W-1:0] raw;
  } reading_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    dz;
    sog_chan_e               ch;
  } scaled_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side drive variables, all known from time zero.
  logic                 drv_valid = 1'b0;
  logic [CH_W-1:0]      drv_ch = '0;
  logic [RAW_W-1:0]     drv_raw = '0;
  logic                 out_rdy = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [SENS_W-1:0]    cfg_data = '0;

  sog_in_if  in_if ();
  sog_out_if out_if ();

  assign in_if.valid      = drv_valid;
  assign in_if.channel    = drv_ch;
  assign in_if.raw_sample = drv_raw;
  assign out_if.ready     = out_rdy;

  sensor_offset_gain_scaler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Calibration registers as the predictor sees them, and the next set to write.
  logic [OFS_W-1:0]         ofs_cal [NUM_CH];
  logic signed [SENS_W-1:0] sens_cal [NUM_CH];
  logic [OFS_W-1:0]         ofs_next [NUM_CH];
  logic [SENS_W-1:0]        sens_next [NUM_CH];

  reading_t reading_q[$];
  scaled_t  scaled_q[$];

  logic in_taken = 1'b0;
  bit   no_gaps = 1'b0;
  bit   choke_req = 1'b0;
  int   n_sent = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   quiet_cycles = 0;

  // Offset removal, scaling by 1000, signed division truncated toward zero and saturation; a zero divisor gives zero.
  function automatic scaled_t calibrate_reading(sog_chan_e ch, logic [RAW_W-1:0] raw);
    scaled_t r;
    int      diff;
    int      divisor;
    int      quot;
    diff    = int'(raw) - int'(ofs_cal[ch]);
    divisor = int'(sens_cal[ch]);
    r.ch    = ch;
    if (divisor == 0) begin
      r.value = '0;
      r.dz    = 1'b1;
    end else begin
      quot = (diff * SCALE_FACTOR) / divisor;
      if (quot > OUT_MAX) quot = OUT_MAX;
      if (quot < -OUT_MAX) quot = -OUT_MAX;
      r.value = OUT_W'(quot);
      r.dz    = 1'b0;
    end
    return r;
  endfunction

  // Offsets lean toward the rails; divisors toward zero, unity and the extremes.
  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return OFS_W'($urandom);
    endcase
  endfunction

  function automatic logic [SENS_W-1:0] pick_divisor();
    case ($urandom_range(9))
      0: return '0;
      1: return SENS_W'(1);
      2: return SENS_W'(-1);
      3: return SENS_W'(-4096);
      4: return ($urandom_range(1) != 0) ? SENS_W'(4095) : SENS_W'(-4095);
      default: return SENS_W'($urandom);
    endcase
  endfunction

  // Input driver: holds a beat until it is taken, then offers the next one.
  always @(negedge clk) begin : reading_drive
    logic     hold;
    reading_t cur;
    hold = drv_valid && !in_taken;
    if (rst_n && !hold) begin
      if (reading_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        cur = reading_q.pop_front();
        drv_ch    <= cur.ch;
        drv_raw   <= cur.raw;
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result-side ready: random gaps, plus one long hold-off to back the block up.
  always @(negedge clk) begin : ready_gen
    static bit choke_done = 1'b0;
    static int hold_left = 0;
    logic      rdy;
    if (choke_req && !choke_done) begin
      choke_done = 1'b1;
      hold_left  = CHOKE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else begin
      rdy = no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
    out_rdy <= rdy;
  end

  // Beat monitor: predicts each accepted reading and checks each result beat.
  always @(posedge clk) begin : beat_check
    scaled_t want;
    logic    beat;
    beat = 1'b0;
    in_taken <= rst_n && (in_if.valid === 1'b1) && (in_if.ready === 1'b1);
    if (rst_n) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        scaled_q.push_back(calibrate_reading(sog_chan_e'(in_if.channel), in_if.raw_sample));
        beat = 1'b1;
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        beat = 1'b1;
        n_results <= n_results + 1;
        if (scaled_q.size() == 0) begin
          n_errors = n_errors + 1;
          $display("%0t: unexpected result, expected none, actual value %0d dz %0b ch %0d",
                   $time, out_if.scaled_value, out_if.divide_by_zero, out_if.result_channel);
        end else begin
          want = scaled_q.pop_front();
          if (out_if.scaled_value !== want.value || out_if.divide_by_zero !== want.dz ||
              out_if.result_channel !== want.ch) begin
            n_errors = n_errors + 1;
            $display("%0t: mismatch, expected value %0d dz %0b ch %0d, actual value %0d dz %0b ch %0d",
                     $time, want.value, want.dz, want.ch, out_if.scaled_value,
                     out_if.divide_by_zero, out_if.result_channel);
          end
        end
      end
      quiet_cycles <= beat ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("sensor_offset_gain_scaler verification failed");
    $finish;
  end

  task automatic queue_reading(sog_chan_e ch, logic [RAW_W-1:0] raw);
    reading_t r;
    r.ch  = ch;
    r.raw = raw;
    reading_q.push_back(r);
    n_sent = n_sent + 1;
  endtask

  task automatic wait_drained();
    while (n_results != n_sent) @(negedge clk);
  endtask

  // Writes all eight calibration registers from ofs_next and sens_next.
  task automatic write_cal_set();
    for (int c = 0; c < NUM_CH; c++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= sog_reg_e'(int'(REG_X_OFS) + c);
      cfg_data  <= SENS_W'(ofs_next[c]);
      ofs_cal[c] = ofs_next[c];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= sog_reg_e'(int'(REG_X_SENS) + c);
      cfg_data  <= sens_next[c];
      sens_cal[c] = $signed(sens_next[c]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Both rails on every channel.
  task automatic queue_rails();
    for (int c = 0; c < NUM_CH; c++) begin
      queue_reading(sog_chan_e'(c), '0);
      queue_reading(sog_chan_e'(c), '1);
    end
  endtask

  // One random phase: fresh calibration, then a burst of readings.
  task automatic random_phase(int n_items, bit calm, bit choke);
    sog_chan_e        ch;
    logic [RAW_W-1:0] raw;
    wait_drained();
    for (int c = 0; c < NUM_CH; c++) begin
      ofs_next[c]  = pick_offset();
      sens_next[c] = pick_divisor();
    end
    write_cal_set();
    @(posedge clk);
    no_gaps   = calm;
    choke_req = choke;
    for (int i = 0; i < n_items; i++) begin
      ch = sog_chan_e'($urandom_range(NUM_CH - 1));
      case ($urandom_range(7))
        0: raw = '0;
        1: raw = '1;
        2: raw = RAW_W'(int'(ofs_cal[ch]) + $urandom_range(6) - 3);
        default: raw = RAW_W'($urandom);
      endcase
      queue_reading(ch, raw);
    end
  endtask

  initial begin : sequencer
    for (int c = 0; c < NUM_CH; c++) begin
      ofs_cal[c]  = OFS_RESET[c];
      sens_cal[c] = $signed(SENS_RESET[c]);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration, rails on every channel.
    @(posedge clk);
    queue_rails();

    // Full-scale results, unity divisors of both signs and the most negative divisor.
    wait_drained();
    ofs_next  = '{12'd0, 12'd4095, 12'd0, 12'd4095};
    sens_next = '{SENS_W'(-4096), SENS_W'(-1), SENS_W'(1), SENS_W'(4095)};
    write_cal_set();
    @(posedge clk);
    queue_rails();

    // Zero divisors on two channels, a divisor of -4095 on another.
    wait_drained();
    ofs_next  = '{12'd4095, 12'd0, 12'd2048, 12'd1};
    sens_next = '{SENS_W'(0), SENS_W'(-4095), SENS_W'(0), SENS_W'(-1)};
    write_cal_set();
    @(posedge clk);
    queue_rails();

    // Random phases: one without gaps, one with a long result-side hold-off.
    for (int p = 0; p < N_PHASES; p++) begin
      random_phase(PHASE_ITEMS, p == 1, p == 3);
    end
    wait_drained();
    repeat (PIPE_LAT + 10) @(negedge clk);

    if (scaled_q.size() != 0) begin
      n_errors = n_errors + 1;
      $display("%0t: %0d results still expected, actual none", $time, scaled_q.size());
    end
    if (n_errors == 0) begin
      $display("sensor_offset_gain_scaler verification clean");
    end else begin
      $display("sensor_offset_gain_scaler verification failed");
    end
    $finish;
  end

endmodule
